[design/b64_pkg.sv]
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types, constants and alphabet functions of the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64_pkg;

    // register map
    localparam int unsigned REG_DIRECTION = 0;
    localparam int unsigned NUM_REGS      = 1;
    localparam int unsigned PADDR_W       = 3;

    // direction codes
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // most results one item can cause
    localparam int unsigned MAX_RESULTS = 4;
    localparam int unsigned COUNT_W     = 3;

    // pad character '='
    localparam logic [7:0] PAD_CHAR = 8'd61;

    // sextet codes beyond the alphabet
    localparam logic [6:0] SEXT_PAD = 7'd64;
    localparam logic [6:0] SEXT_BAD = 7'd65;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_result;
        logic       bad_char;
    } t_out_item;

    // results caused by one item, slot 0 goes out first
    typedef struct packed {
        logic [COUNT_W-1:0]              count;
        logic [MAX_RESULTS-1:0][7:0]     bytes;
        logic                            eom;
        logic                            bad;
    } t_burst;

    // group state seen from the top level
    typedef struct packed {
        logic [1:0] fill;
        logic [1:0] pads;
        logic       bad;
    } t_grp_status;

    // sextet to alphabet character
    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'd65 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'd97 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'd48 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'd43;
        end else begin
            c = 8'd47;
        end
        return c;
    endfunction

    // character to sextet, or the pad or bad code
    function automatic logic [6:0] dec_sextet(input logic [7:0] c);
        logic [6:0] v;
        if (c >= 8'd65 && c <= 8'd90) begin
            v = c[6:0] - 7'd65;
        end else if (c >= 8'd97 && c <= 8'd122) begin
            v = c[6:0] - 7'd97 + 7'd26;
        end else if (c >= 8'd48 && c <= 8'd57) begin
            v = c[6:0] - 7'd48 + 7'd52;
        end else if (c == 8'd43) begin
            v = 7'd62;
        end else if (c == 8'd47) begin
            v = 7'd63;
        end else if (c == PAD_CHAR) begin
            v = SEXT_PAD;
        end else begin
            v = SEXT_BAD;
        end
        return v;
    endfunction

endpackage

[design/b64_group.sv]
// ----------------------------------------------------------------------------
// b64_group
// Group state and the encode/decode logic that turns one item into a burst.
// ----------------------------------------------------------------------------
module b64_group
    import b64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_dir,
    input  logic        i_clear,
    input  logic        i_accept,
    input  t_in_item    i_item,
    output t_burst      o_burst,
    output t_grp_status o_status
);

    logic [23:0] r_bits, n_bits;
    logic [1:0]  r_fill, n_fill;
    logic [1:0]  r_pads, n_pads;
    logic        r_bad,  n_bad;

    // encode path
    logic [23:0] enc_bits;
    logic [23:0] enc_shift;
    logic [1:0]  enc_fill;
    logic        enc_done;
    logic [MAX_RESULTS-1:0][7:0] enc_chars;

    // decode path
    logic [6:0]  dec_code;
    logic [5:0]  dec_v;
    logic [2:0]  dec_pads;
    logic        dec_bad;
    logic [2:0]  dec_fill;
    logic        dec_done;
    logic [23:0] dec_bits;
    logic [23:0] dec_shift;
    logic [2:0]  dec_total;
    logic [COUNT_W-1:0] dec_nbytes;

    // encode: gather bytes, expand the group into four characters
    always_comb begin
        enc_bits = {r_bits[15:0], i_item.in_byte};
        enc_fill = r_fill + 2'd1;
        enc_done = (enc_fill == 2'd3) || i_item.end_of_message;
        unique case (enc_fill)
            2'd1:    enc_shift = {enc_bits[7:0], 16'd0};
            2'd2:    enc_shift = {enc_bits[15:0], 8'd0};
            default: enc_shift = enc_bits;
        endcase
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (2'(i) <= enc_fill) begin
                enc_chars[i] = enc_char(enc_shift[23 - 6*i -: 6]);
            end else begin
                enc_chars[i] = PAD_CHAR;
            end
        end
    end

    // decode: map the character, gather sextets, split into bytes
    always_comb begin
        dec_code = dec_sextet(i_item.in_byte);
        dec_pads = {1'b0, r_pads};
        dec_bad  = r_bad;
        dec_v    = dec_code[5:0];
        if (dec_code == SEXT_PAD) begin
            dec_pads = dec_pads + 3'd1;
            dec_v    = 6'd0;
        end else if (dec_code == SEXT_BAD) begin
            dec_bad = 1'b1;
            dec_v   = 6'd0;
        end
        dec_bits = {r_bits[17:0], dec_v};
        dec_fill = {1'b0, r_fill} + 3'd1;
        dec_done = (dec_fill == 3'd4) || i_item.end_of_message;
        unique case (dec_fill)
            3'd1:    dec_shift = {dec_bits[5:0], 18'd0};
            3'd2:    dec_shift = {dec_bits[11:0], 12'd0};
            3'd3:    dec_shift = {dec_bits[17:0], 6'd0};
            default: dec_shift = dec_bits;
        endcase
        dec_total  = dec_pads + (3'd4 - dec_fill);
        dec_nbytes = (dec_total >= 3'd3) ? '0 : COUNT_W'(3'd3 - dec_total);
    end

    // select the burst and the next group state
    always_comb begin
        o_burst = '0;
        n_bits  = r_bits;
        n_fill  = r_fill;
        n_pads  = r_pads;
        n_bad   = r_bad;
        if (i_dir == DIR_ENCODE) begin
            if (enc_done) begin
                o_burst.count = COUNT_W'(MAX_RESULTS);
                o_burst.bytes = enc_chars;
                o_burst.eom   = i_item.end_of_message;
                n_bits = '0;
                n_fill = '0;
                n_pads = '0;
                n_bad  = 1'b0;
            end else begin
                n_bits = enc_bits;
                n_fill = enc_fill;
            end
        end else begin
            if (dec_done) begin
                o_burst.count    = dec_nbytes;
                o_burst.bytes[0] = dec_shift[23:16];
                o_burst.bytes[1] = dec_shift[15:8];
                o_burst.bytes[2] = dec_shift[7:0];
                o_burst.bytes[3] = 8'd0;
                o_burst.eom      = i_item.end_of_message;
                o_burst.bad      = dec_bad;
                n_bits = '0;
                n_fill = '0;
                n_pads = '0;
                n_bad  = 1'b0;
            end else begin
                n_bits = dec_bits;
                n_fill = dec_fill[1:0];
                n_pads = (dec_pads > 3'd3) ? 2'd3 : dec_pads[1:0];
                n_bad  = dec_bad;
            end
        end
    end

    // group state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_bits <= '0;
            r_fill <= '0;
            r_pads <= '0;
            r_bad  <= 1'b0;
        end else if (i_accept) begin
            r_bits <= n_bits;
            r_fill <= n_fill;
            r_pads <= n_pads;
            r_bad  <= n_bad;
        end
    end

    assign o_status.fill = r_fill;
    assign o_status.pads = r_pads;
    assign o_status.bad  = r_bad;

endmodule

[design/b64_out.sv]
// ----------------------------------------------------------------------------
// b64_out
// Burst buffer and output register: sends a burst one item per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module b64_out
    import b64_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_burst    i_burst,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    logic [MAX_RESULTS-1:0][7:0] r_buf;
    logic [COUNT_W-1:0]          r_rem;
    logic                        r_eom;
    logic                        r_bad;
    logic                        r_ovalid;
    t_out_item                   r_odata;

    logic out_take;
    logic in_acc;
    logic load;

    // output register free or emptied this cycle
    assign out_take   = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_rem > COUNT_W'(1)) || ((r_rem == COUNT_W'(1)) && !out_take);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign load       = in_acc && (i_burst.count != '0);

    // burst buffer, shifts toward slot 0 as items leave
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (load) begin
            r_rem <= i_burst.count;
        end else if (out_take && (r_rem != '0)) begin
            r_rem <= r_rem - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_buf <= i_burst.bytes;
            r_eom <= i_burst.eom;
            r_bad <= i_burst.bad;
        end else if (out_take && (r_rem != '0)) begin
            r_buf <= {8'd0, r_buf[MAX_RESULTS-1:1]};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_take) begin
            r_ovalid <= (r_rem != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && (r_rem != '0)) begin
            r_odata.out_byte      <= r_buf[0];
            r_odata.end_of_result <= r_eom && (r_rem == COUNT_W'(1));
            r_odata.bad_char      <= r_bad;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

endmodule

[design/base64_stream_codec.sv]
// ----------------------------------------------------------------------------
// base64_stream_codec
// Streaming Base64 encoder/decoder with an APB direction register.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one byte (encode) or one
// character (decode) per item, with end_of_message on the last item.
// Output channel: o_out_valid / i_out_stall carry one character (encode) or
// one byte (decode) per item; end_of_result marks the last result of a message.
// Register 0 (byte address 0) holds direction: 0 encode, 1 decode. A write to
// it clears the group being gathered. pready is always high.
// The first result of a group passes through the burst buffer and then the
// output register. Results leave one per cycle while the output is not
// stalled, from a burst buffer of four entries; the input is stalled while more
// than one result of the previous burst is still waiting, or while the last
// one is waiting and the output register cannot take it.
// Items that only add to a group are taken every cycle while the buffer is
// free. A stalled output holds its item; the buffer fills behind it.
// Reset clears direction, the group state, the burst buffer and the output valid flag.
// ----------------------------------------------------------------------------
module base64_stream_codec
    import b64_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    output logic               o_in_stall,
    // output channel
    output logic               o_out_valid,
    output t_out_item          o_out_data,
    input  logic               i_out_stall,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic        r_dir;
    logic        cfg_wr;
    logic        dir_sel;
    logic        in_acc;
    t_burst      burst;
    t_grp_status grp_status;

    // configuration register
    assign pready  = 1'b1;
    assign dir_sel = (paddr[PADDR_W-1:2] == (PADDR_W-2)'(REG_DIRECTION));
    assign cfg_wr  = psel && penable && pwrite && pready && dir_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_ENCODE;
        end else if (cfg_wr) begin
            r_dir <= pwdata[0];
        end
    end

    assign prdata = dir_sel ? {31'd0, r_dir} : 32'd0;

    assign in_acc = i_in_valid && !o_in_stall;

    // group gathering and conversion
    b64_group u_group (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dir    (r_dir),
        .i_clear  (cfg_wr),
        .i_accept (in_acc),
        .i_item   (i_in_data),
        .o_burst  (burst),
        .o_status (grp_status)
    );

    // burst buffer and output register
    b64_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_burst     (burst),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    // a direction write leaves an empty group
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (grp_status.fill == 2'd0) && (grp_status.pads == 2'd0)
                   && !grp_status.bad)
        else $error("group not cleared after direction write");

    // encoding never gathers a full group without emitting it
    a_enc_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dir == DIR_ENCODE) && $stable(r_dir) && !$past(cfg_wr)
            |-> (grp_status.fill != 2'd3) || ($past(r_dir) == DIR_DECODE))
        else $error("encode group overfilled");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("results pending after reset");

endmodule
